// File: src/assert_macros.svh
// Assertion macros shared by the hash table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPHT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpht check failed");

// Next-cycle implication, disabled during reset.
`define LPHT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpht check failed");

`endif

// File: src/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; used by the interfaces, the hash unit and the top level.
`default_nettype none

package lpht_pkg;

  localparam int OP_W          = 2;
  localparam int KEY_PORT_W    = 64;
  localparam int VALUE_PORT_W  = 32;
  localparam int STATUS_W      = 3;
  localparam int SLOT_PORT_W   = 6;
  localparam int COUNT_PORT_W  = 7;
  localparam int CFG_W         = 7;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 7'd44;

  // djb2: h = h * 33 + byte, seeded with 5381.
  localparam int DJB2_SEED  = 5381;
  localparam int DJB2_SHIFT = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW      = 3'd0,
    ST_REPLACED = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

endpackage

`default_nettype wire

// File: src/lpht_ifs.sv
// Handshake channel interfaces for the hash table: request, response, config.
// Depends on lpht_pkg for field widths.
`default_nettype none

interface lpht_req_if import lpht_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [KEY_PORT_W-1:0]   key;
  logic [VALUE_PORT_W-1:0] value_in;

  modport source (output valid, output op, output key, output value_in, input ready);
  modport sink   (input valid, input op, input key, input value_in, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [VALUE_PORT_W-1:0] value_out;
  logic [SLOT_PORT_W-1:0]  slot;
  logic [COUNT_PORT_W-1:0] entry_count;

  modport source (output valid, output status, output value_out, output slot,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input value_out, input slot,
                  input entry_count, output ready);
endinterface

interface lpht_cfg_if import lpht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/lpht_hash.sv
// Iterative djb2 hash unit: one key byte per step, remainder kept modulo SLOTS.
// Also produces the normalized key. Depends on lpht_pkg.
`default_nettype none

module lpht_hash import lpht_pkg::*; #(
  parameter int SLOTS     = 64,
  parameter int KEY_BYTES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [KEY_PORT_W-1:0]        key,
  output logic                         done,
  output logic [$clog2(SLOTS)-1:0]     slot,
  output logic [8*KEY_BYTES-1:0]       key_norm
);

  localparam int SW  = $clog2(SLOTS);
  localparam int BW  = $clog2(KEY_BYTES + 1);
  localparam int KW  = 8 * KEY_BYTES;
  localparam int XW  = $clog2(33 * SLOTS + 256);
  localparam int MW  = 31;
  localparam int PW  = XW + MW;
  localparam int QW  = XW;
  localparam logic [MW-1:0] RECIP    = MW'((64'd1 << 32) / SLOTS);
  localparam logic [SW-1:0] SEED_REM = SW'(DJB2_SEED % SLOTS);
  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_ADD  = 4'b0010,
    H_MUL  = 4'b0100,
    H_RED  = 4'b1000
  } hphase_t;

  hphase_t               phase;
  logic [KEY_PORT_W-1:0] kshift;
  logic [KEY_PORT_W-1:0] key_raw;
  logic [BW-1:0]         bidx;
  logic [SW-1:0]         rem;
  logic [XW-1:0]         x;
  logic [QW-1:0]         q;

  logic [7:0]            byte_cur;
  logic                  hit_end;
  logic [XW-1:0]         x_next;
  logic [PW-1:0]         prod;
  logic [XW-1:0]         qs;
  logic [XW-1:0]         t;
  logic [XW-1:0]         t_red;
  logic [KEY_PORT_W-1:0] keep;
  logic [KEY_PORT_W-1:0] masked;

  always_comb begin
    byte_cur = kshift[KEY_PORT_W-1 -: 8];
    hit_end  = (bidx == BW'(KEY_BYTES)) || (byte_cur == 8'd0);
    x_next   = (XW'(rem) << DJB2_SHIFT) + XW'(rem) + XW'(byte_cur);
    prod     = PW'(x) * PW'(RECIP);
    qs       = XW'(q * SLOTS);
    t        = x - qs;
    t_red    = (t >= XW'(SLOTS)) ? t - XW'(SLOTS) : t;
    // Bytes from the first zero byte on are not part of the key.
    keep     = ~({KEY_PORT_W{1'b1}} >> {bidx, 3'b000});
    masked   = key_raw & keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        H_IDLE: begin
          if (start) begin
            kshift  <= key;
            key_raw <= key;
            bidx    <= '0;
            rem     <= SEED_REM;
            phase   <= H_ADD;
          end
        end
        H_ADD: begin
          if (hit_end) begin
            key_norm <= masked[KEY_PORT_W-1 -: KW];
            done     <= 1'b1;
            phase    <= H_IDLE;
          end else begin
            kshift <= kshift << 8;
            bidx   <= bidx + 1'b1;
            if (POW2) begin
              rem <= SW'(x_next);
            end else begin
              x     <= x_next;
              phase <= H_MUL;
            end
          end
        end
        H_MUL: begin
          // Reciprocal estimate of the quotient; low by at most one.
          q     <= QW'(prod >> 32);
          phase <= H_RED;
        end
        H_RED: begin
          rem   <= SW'(t_red);
          phase <= H_ADD;
        end
        default: phase <= H_IDLE;
      endcase
    end
  end

  assign slot = rem;

endmodule

`default_nettype wire

// File: src/linear_probe_hash_table_unit.sv
// Linear probing hash table: top level with slot stores, probe sequencer, config.
// Depends on lpht_pkg, the lpht interfaces, lpht_hash and assert_macros.svh.
`default_nettype none

// One request is handled at a time. After reset the slot flags are cleared to
// empty before the first request is taken. After a request is accepted, the hash
// unit reads the key a byte at a time up to the first zero byte (going through
// H_ADD, H_MUL and H_RED for each byte when SLOTS is not a power of two, for the
// reduction modulo SLOTS) and then finds the end of the key; the start slot is
// then handed to the sequencer, the slot read is started, the slots are probed
// in turn (at most SLOTS), and the result goes to the output register when free.
// The single read port of the slot stores sets the probe rate.
// An op code of 3 skips the hash and the probe and answers not found. max_entries
// may be written at any time the block is idle.

`include "assert_macros.svh"

module linear_probe_hash_table_unit import lpht_pkg::*; #(
  parameter int SLOTS      = 64,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  lpht_req_if.sink     req,
  lpht_rsp_if.source   rsp,
  lpht_cfg_if.sink     cfg
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam int KW = 8 * KEY_BYTES;
  localparam logic [1:0] FLAG_EMPTY = 2'b00;
  localparam logic [1:0] FLAG_LIVE  = 2'b10;
  localparam logic [1:0] FLAG_TOMB  = 2'b01;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_PROBE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                 state;
  logic [SW-1:0]          clr;
  logic [SW-1:0]          raddr;
  logic [SW-1:0]          eaddr;
  logic [SW-1:0]          cnt;
  logic [OP_W-1:0]        op_r;
  logic [VALUE_BITS-1:0]  val_r;
  logic                   have_tomb;
  logic [SW-1:0]          tomb;
  logic [CW-1:0]          live_count;
  logic [CFG_W-1:0]       max_entries;
  logic [STATUS_W-1:0]    res_status;
  logic [VALUE_BITS-1:0]  res_value;
  logic [SW-1:0]          res_slot;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [VALUE_BITS-1:0]  out_value;
  logic [SW-1:0]          out_slot;
  logic [CW-1:0]          out_count;

  // Slot stores.
  logic [1:0]             flag_mem [SLOTS];
  logic [KW-1:0]          key_mem  [SLOTS];
  logic [VALUE_BITS-1:0]  val_mem  [SLOTS];
  logic [1:0]             flag_rd;
  logic [KW-1:0]          key_rd;
  logic [VALUE_BITS-1:0]  val_rd;

  logic                   hash_start;
  logic                   hash_done;
  logic [SW-1:0]          hash_slot;
  logic [KW-1:0]          key_n;

  logic [SW-1:0]          raddr_next;
  logic                   last;
  logic                   live;
  logic                   tombf;
  logic                   match;
  logic                   p_fin;
  logic                   p_new;
  logic                   p_rep;
  logic                   p_del;
  logic                   p_tomb_set;
  logic                   ins_try;
  logic [SW-1:0]          ins_addr;
  logic [STATUS_W-1:0]    p_status;
  logic [VALUE_BITS-1:0]  p_value;
  logic [SW-1:0]          p_slot;
  logic                   flag_we;
  logic [SW-1:0]          flag_waddr;
  logic [1:0]             flag_wdata;
  logic                   key_we;
  logic                   val_we;
  logic [SW-1:0]          wr_addr;
  logic                   out_load;

  lpht_hash #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk      (clk),
    .rst      (rst),
    .start    (hash_start),
    .key      (req.key),
    .done     (hash_done),
    .slot     (hash_slot),
    .key_norm (key_n)
  );

  assign req.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign hash_start = req.valid && req.ready &&
                      ((req.op == OP_INSERT) || (req.op == OP_REMOVE) ||
                       (req.op == OP_LOOKUP));

  assign raddr_next = (raddr == SW'(SLOTS - 1)) ? '0 : raddr + 1'b1;

  // Probe decision for the slot whose flags, key and value arrived this cycle.
  always_comb begin
    live       = flag_rd[1];
    tombf      = flag_rd[0];
    match      = (key_rd == key_n);
    last       = (cnt == SW'(SLOTS - 1));
    p_fin      = 1'b0;
    p_new      = 1'b0;
    p_rep      = 1'b0;
    p_del      = 1'b0;
    p_tomb_set = 1'b0;
    ins_try    = 1'b0;
    ins_addr   = have_tomb ? tomb : eaddr;
    p_status   = ST_NOTFOUND;
    p_value    = '0;
    p_slot     = '0;
    if (op_r == OP_INSERT) begin
      if (live) begin
        if (match) begin
          p_fin    = 1'b1;
          p_rep    = 1'b1;
          p_status = ST_REPLACED;
          p_value  = val_rd;
          p_slot   = eaddr;
        end
      end else if (tombf) begin
        p_tomb_set = !have_tomb;
      end else begin
        ins_try = 1'b1;
      end
      // The whole table was scanned without an empty slot: fall back on
      // the first tombstone seen, if any.
      if (!p_fin && !ins_try && last) begin
        if (have_tomb || p_tomb_set) begin
          ins_try = 1'b1;
        end else begin
          p_fin    = 1'b1;
          p_status = ST_FULL;
        end
      end
      if (ins_try) begin
        p_fin = 1'b1;
        if (LW'(live_count) >= LW'(max_entries)) begin
          p_status = ST_FULL;
        end else begin
          p_new    = 1'b1;
          p_status = ST_NEW;
          p_slot   = ins_addr;
        end
      end
    end else begin
      if (live) begin
        if (match) begin
          p_fin    = 1'b1;
          p_del    = (op_r == OP_REMOVE);
          p_status = ST_FOUND;
          p_value  = val_rd;
          p_slot   = eaddr;
        end
      end else if (!tombf) begin
        p_fin = 1'b1;
      end
      if (last) begin
        p_fin = 1'b1;
      end
    end
  end

  always_comb begin
    flag_we    = (state == S_CLEAR) || ((state == S_PROBE) && (p_new || p_del));
    flag_waddr = (state == S_CLEAR) ? clr : (p_new ? ins_addr : eaddr);
    flag_wdata = (state == S_CLEAR) ? FLAG_EMPTY : (p_new ? FLAG_LIVE : FLAG_TOMB);
    key_we     = (state == S_PROBE) && p_new;
    val_we     = (state == S_PROBE) && (p_new || p_rep);
    wr_addr    = p_new ? ins_addr : eaddr;
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rd <= flag_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_n;
    end
    key_rd <= key_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_r;
    end
    val_rd <= val_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_entries <= cfg.data;
    end
  end

  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      live_count <= '0;
      have_tomb  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == SW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op_r      <= req.op;
            val_r     <= VALUE_BITS'(req.value_in);
            have_tomb <= 1'b0;
            if (hash_start) begin
              state <= S_HASH;
            end else begin
              res_status <= ST_NOTFOUND;
              res_value  <= '0;
              res_slot   <= '0;
              state      <= S_DONE;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            raddr <= hash_slot;
            cnt   <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          raddr <= raddr_next;
          state <= S_PROBE;
        end
        S_PROBE: begin
          raddr <= raddr_next;
          cnt   <= cnt + 1'b1;
          if (p_tomb_set) begin
            have_tomb <= 1'b1;
            tomb      <= eaddr;
          end
          if (p_new) begin
            live_count <= live_count + 1'b1;
          end else if (p_del && (live_count != '0)) begin
            live_count <= live_count - 1'b1;
          end
          if (p_fin) begin
            res_status <= p_status;
            res_value  <= p_value;
            res_slot   <= p_slot;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // The slot being read this cycle becomes the slot under evaluation next cycle.
  always_ff @(posedge clk) begin
    eaddr <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_slot   <= res_slot;
      out_count  <= live_count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.value_out   = VALUE_PORT_W'(out_value);
  assign rsp.slot        = SLOT_PORT_W'(out_slot);
  assign rsp.entry_count = COUNT_PORT_W'(out_count);

  `LPHT_ASSERT_NXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `LPHT_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, live_count <= CW'(SLOTS))
  `LPHT_ASSERT_IMP(a_new_below_limit, clk, rst, key_we, LW'(live_count) < LW'(max_entries))
  `LPHT_ASSERT_NXT(a_replace_keeps_count, clk, rst, (state == S_PROBE) && p_rep, $stable(live_count))

endmodule

`default_nettype wire
